// File: rtl/ncc_template_match_map_macros.svh
// Assertion macros for the template match block and its checker
`ifndef NCC_TEMPLATE_MATCH_MAP_MACROS_SVH
`define NCC_TEMPLATE_MATCH_MAP_MACROS_SVH

// same-cycle implication
`define NTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ntm_pkg.sv
// Shared types, widths and codes of the template match block
package ntm_pkg;

  localparam int TPL_SIZE_DEF   = 5;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SIZE_W     = 11;
  localparam int CMP_W      = 13;
  localparam int COORD_W    = 10;
  localparam int SCORE_W    = 16;
  localparam int TPL_BYTES  = 25;

  // sized for templates up to 8x8
  localparam int SUM_W = 14;
  localparam int SQ_W  = 22;
  localparam int V_W   = 28;
  localparam int NUM_W = 29;
  localparam int AN_W  = 28;
  localparam int P_W   = 56;
  localparam int PP_W  = 68;
  localparam int AN2_W = 56;
  localparam int R_W   = 69;
  localparam int FW    = 104;
  localparam int Q_W   = 15;
  localparam int BIT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_TPL_WORD_0   = 3'd2,
    REG_TPL_WORD_1   = 3'd3,
    REG_TPL_WORD_2   = 3'd4,
    REG_TPL_WORD_3   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ACC,
    ST_START,
    ST_SCORE,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_MUL,
    SP_DIFF,
    SP_PROD,
    SP_SCALE,
    SP_ITER,
    SP_DONE
  } score_phase_t;

  typedef struct packed {
    logic [SUM_W-1:0] si;
    logic [SUM_W-1:0] st;
    logic [SQ_W-1:0]  sit;
    logic [SQ_W-1:0]  si2;
    logic [SQ_W-1:0]  st2;
  } sums_t;

endpackage

// File: rtl/ntm_ram.sv
// Generic single-port-write, registered-read RAM
module ntm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ntm_cell.sv
// Window column cell: holds one column of the window, shifts toward column 0
module ntm_cell #(
  parameter int TPL_SIZE = ntm_pkg::TPL_SIZE_DEF
) (
  input  logic                                     clk,
  input  logic                                     shift,
  input  logic [TPL_SIZE-1:0][ntm_pkg::PIX_W-1:0]  col_in,
  output logic [TPL_SIZE-1:0][ntm_pkg::PIX_W-1:0]  col
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

endmodule

// File: rtl/ntm_score.sv
// Score unit: variances, numerator and bit-serial exact Q1.14 quotient search
module ntm_score #(
  parameter int TPL_SIZE = ntm_pkg::TPL_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  ntm_pkg::sums_t                     sums,
  output logic                               done,
  output logic signed [ntm_pkg::SCORE_W-1:0] score
);

  localparam int N     = TPL_SIZE * TPL_SIZE;
  localparam int NM1SQ = (N - 1) * (N - 1);
  localparam int NSQ   = N * N;

  ntm_pkg::score_phase_t phase, phase_next;

  ntm_pkg::sums_t                  sums_r;
  logic [ntm_pkg::V_W-1:0]         m_ii, m_tt, m_it, n_si2, n_st2, n_sit;
  logic [ntm_pkg::V_W-1:0]         vi, vt;
  logic signed [ntm_pkg::NUM_W-1:0] num;
  logic [ntm_pkg::AN_W-1:0]        an;
  logic [ntm_pkg::P_W-1:0]         p;
  logic [ntm_pkg::AN2_W-1:0]       an2;
  logic                            neg, zero;
  logic [ntm_pkg::PP_W-1:0]        pp;
  logic [ntm_pkg::R_W-1:0]         r_prod;
  logic signed [ntm_pkg::FW-1:0]   f_acc, a_acc, p_acc, r_val, ft;
  logic [ntm_pkg::Q_W-1:0]         lo;
  logic [ntm_pkg::BIT_W-1:0]       bit_idx;
  logic                            take;

  always_comb begin
    an     = num[ntm_pkg::NUM_W-1] ? ntm_pkg::AN_W'(-num) : ntm_pkg::AN_W'(num);
    pp     = ntm_pkg::PP_W'(p) * ntm_pkg::PP_W'(NM1SQ);
    r_prod = ntm_pkg::R_W'(an2) * ntm_pkg::R_W'(NSQ);
    ft     = f_acc + a_acc + p_acc;
    take   = (ft <= r_val);
    done   = (phase == ntm_pkg::SP_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ntm_pkg::SP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      ntm_pkg::SP_IDLE:  if (start) phase_next = ntm_pkg::SP_MUL;
      ntm_pkg::SP_MUL:   phase_next = ntm_pkg::SP_DIFF;
      ntm_pkg::SP_DIFF:  phase_next = ntm_pkg::SP_PROD;
      ntm_pkg::SP_PROD:  phase_next = ntm_pkg::SP_SCALE;
      ntm_pkg::SP_SCALE: phase_next = ntm_pkg::SP_ITER;
      ntm_pkg::SP_ITER:  if (bit_idx == '0) phase_next = ntm_pkg::SP_DONE;
      ntm_pkg::SP_DONE:  phase_next = ntm_pkg::SP_IDLE;
      default:           phase_next = ntm_pkg::SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (phase)
      ntm_pkg::SP_IDLE: begin
        if (start) begin
          sums_r <= sums;
        end
      end
      ntm_pkg::SP_MUL: begin
        m_ii  <= ntm_pkg::V_W'(sums_r.si) * ntm_pkg::V_W'(sums_r.si);
        m_tt  <= ntm_pkg::V_W'(sums_r.st) * ntm_pkg::V_W'(sums_r.st);
        m_it  <= ntm_pkg::V_W'(sums_r.si) * ntm_pkg::V_W'(sums_r.st);
        n_si2 <= ntm_pkg::V_W'(N) * ntm_pkg::V_W'(sums_r.si2);
        n_st2 <= ntm_pkg::V_W'(N) * ntm_pkg::V_W'(sums_r.st2);
        n_sit <= ntm_pkg::V_W'(N) * ntm_pkg::V_W'(sums_r.sit);
      end
      ntm_pkg::SP_DIFF: begin
        vi  <= n_si2 - m_ii;
        vt  <= n_st2 - m_tt;
        num <= $signed({1'b0, n_sit}) - $signed({1'b0, m_it});
      end
      ntm_pkg::SP_PROD: begin
        p    <= ntm_pkg::P_W'(vi) * ntm_pkg::P_W'(vt);
        an2  <= ntm_pkg::AN2_W'(an) * ntm_pkg::AN2_W'(an);
        neg  <= num[ntm_pkg::NUM_W-1];
        zero <= (vi == '0) || (vt == '0);
      end
      ntm_pkg::SP_SCALE: begin
        f_acc   <= $signed(ntm_pkg::FW'(pp));
        p_acc   <= $signed(ntm_pkg::FW'(pp) << (2 * ntm_pkg::Q_W));
        a_acc   <= -$signed(ntm_pkg::FW'(pp) << (ntm_pkg::Q_W + 1));
        r_val   <= $signed(ntm_pkg::FW'(r_prod) << (2 * ntm_pkg::Q_W));
        lo      <= '0;
        bit_idx <= ntm_pkg::BIT_W'(ntm_pkg::Q_W - 1);
      end
      ntm_pkg::SP_ITER: begin
        // trial bit: f(lo|b) = f(lo) + a<<(2+k) + P'<<(2+2k)
        if (take) begin
          f_acc       <= ft;
          lo[bit_idx] <= 1'b1;
          a_acc       <= (a_acc + (p_acc <<< 1)) >>> 1;
        end else begin
          a_acc <= a_acc >>> 1;
        end
        p_acc   <= p_acc >>> 2;
        bit_idx <= bit_idx - 1'b1;
      end
      ntm_pkg::SP_DONE: begin
        if (zero) begin
          score <= '0;
        end else if (neg) begin
          score <= -$signed({1'b0, lo});
        end else begin
          score <= $signed({1'b0, lo});
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/ncc_template_match_map.sv
// Top level of the streaming 5x5 normalized cross-correlation map
//
// Pixels enter in raster order on pixel/frame_start with in_valid/in_ready.
// frame_start forces the pixel to column 0, row 0. Each complete window
// position yields one transfer on out_valid/out_ready: score (signed Q1.14),
// win_x/win_y (top-left corner) and last_window on the frame's last window.
// Registers are written on cfg_valid/cfg_ready (always ready) by cfg_index.
// A pixel outside the frame is taken in ST_IDLE alone, a pixel without a full
// window also passes ST_SHIFT, and a pixel closing a window also runs the rotation
// in ST_ACC, the score unit and ST_DONE; no new pixel is taken before ST_IDLE.
// The window rotation over the column cells and the 15-step quotient search
// of the score unit make up most of that work.
// The output register frees the input side: a new pixel is taken while a
// score waits for out_ready; a second score waits until the first is taken.
// Reset clears counters, state and output valid and loads frame 640x480 and
// a zero template. The row store needs no clearing.
module ncc_template_match_map #(
  parameter int TPL_SIZE   = ntm_pkg::TPL_SIZE_DEF,
  parameter int MAX_WIDTH  = ntm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ntm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ntm_pkg::PIX_W-1:0]             pixel,
  input  logic                                  frame_start,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ntm_pkg::SCORE_W-1:0]    score,
  output logic [ntm_pkg::COORD_W-1:0]           win_x,
  output logic [ntm_pkg::COORD_W-1:0]           win_y,
  output logic                                  last_window,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ntm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ntm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = ntm_pkg::PIX_W * (TPL_SIZE - 1);
  localparam int K_W   = $clog2(TPL_SIZE);
  localparam int TPL_N = TPL_SIZE * TPL_SIZE;

  typedef logic [TPL_SIZE-1:0][ntm_pkg::PIX_W-1:0] col_t;

  // configuration
  logic [ntm_pkg::SIZE_W-1:0]     frame_width, frame_height;
  logic [ntm_pkg::CFG_DATA_W-1:0] tpl_word_0, tpl_word_1, tpl_word_2;
  logic [ntm_pkg::PIX_W-1:0]      tpl_word_3;
  logic [ntm_pkg::PIX_W-1:0]      tpl_byte [TPL_N];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ntm_pkg::SIZE_W'(640);
      frame_height <= ntm_pkg::SIZE_W'(480);
      tpl_word_0   <= '0;
      tpl_word_1   <= '0;
      tpl_word_2   <= '0;
      tpl_word_3   <= '0;
    end else if (cfg_valid) begin
      unique case (ntm_pkg::cfg_reg_t'(cfg_index))
        ntm_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[ntm_pkg::SIZE_W-1:0];
        ntm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[ntm_pkg::SIZE_W-1:0];
        ntm_pkg::REG_TPL_WORD_0:   tpl_word_0   <= cfg_data;
        ntm_pkg::REG_TPL_WORD_1:   tpl_word_1   <= cfg_data;
        ntm_pkg::REG_TPL_WORD_2:   tpl_word_2   <= cfg_data;
        ntm_pkg::REG_TPL_WORD_3:   tpl_word_3   <= cfg_data[ntm_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < TPL_N; i++) begin
      if (i < 8) begin
        tpl_byte[i] = tpl_word_0[8*(i%8) +: 8];
      end else if (i < 16) begin
        tpl_byte[i] = tpl_word_1[8*(i%8) +: 8];
      end else if (i < 24) begin
        tpl_byte[i] = tpl_word_2[8*(i%8) +: 8];
      end else if (i == 24) begin
        tpl_byte[i] = tpl_word_3;
      end else begin
        tpl_byte[i] = '0;
      end
    end
  end

  // effective frame size
  logic [EW_W-1:0] ew;
  logic [EH_W-1:0] eh;

  always_comb begin
    if (ntm_pkg::CMP_W'(frame_width) < ntm_pkg::CMP_W'(TPL_SIZE)) begin
      ew = EW_W'(TPL_SIZE);
    end else if (ntm_pkg::CMP_W'(frame_width) > ntm_pkg::CMP_W'(MAX_WIDTH)) begin
      ew = EW_W'(MAX_WIDTH);
    end else begin
      ew = EW_W'(frame_width);
    end
    if (ntm_pkg::CMP_W'(frame_height) < ntm_pkg::CMP_W'(TPL_SIZE)) begin
      eh = EH_W'(TPL_SIZE);
    end else if (ntm_pkg::CMP_W'(frame_height) > ntm_pkg::CMP_W'(MAX_HEIGHT)) begin
      eh = EH_W'(MAX_HEIGHT);
    end else begin
      eh = EH_W'(frame_height);
    end
  end

  // control
  ntm_pkg::ctl_state_t state, state_next;
  logic accept, shift_en, ram_we, score_start, load_out, score_done;

  logic [CW-1:0]   column_count, c0, column_count_next;
  logic [RW-1:0]   row_count, r0, row_count_next;
  logic [EW_W-1:0] c0e, c1;
  logic [EH_W-1:0] r0e, r1;
  logic            in_rng, prod, is_last;

  always_comb begin
    c0  = frame_start ? '0 : column_count;
    r0  = frame_start ? '0 : row_count;
    c0e = EW_W'(c0);
    r0e = EH_W'(r0);
    in_rng  = (c0e < ew) && (r0e < eh);
    prod    = in_rng && (c0e >= EW_W'(TPL_SIZE - 1)) && (r0e >= EH_W'(TPL_SIZE - 1));
    is_last = (c0e == ew - 1'b1) && (r0e == eh - 1'b1);
    c1 = c0e + 1'b1;
    r1 = r0e;
    if (c1 >= ew) begin
      c1 = '0;
      r1 = r0e + 1'b1;
    end
    if (r1 >= eh) begin
      r1 = '0;
    end
    column_count_next = c1[CW-1:0];
    row_count_next    = r1[RW-1:0];
  end

  logic [CW-1:0]              item_col;
  logic [ntm_pkg::PIX_W-1:0]  item_pix;
  logic                       item_prod, item_last;
  logic [ntm_pkg::COORD_W-1:0] item_wx, item_wy;
  logic [K_W-1:0]             k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ntm_pkg::ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_col  <= c0;
      item_pix  <= pixel;
      item_prod <= prod;
      item_last <= is_last;
      item_wx   <= ntm_pkg::COORD_W'(c0e - EW_W'(TPL_SIZE - 1));
      item_wy   <= ntm_pkg::COORD_W'(r0e - EH_W'(TPL_SIZE - 1));
    end
    if (state == ntm_pkg::ST_SHIFT) begin
      k <= '0;
    end else if (state == ntm_pkg::ST_ACC) begin
      k <= k + 1'b1;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    shift_en    = 1'b0;
    ram_we      = 1'b0;
    score_start = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ntm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_rng) state_next = ntm_pkg::ST_SHIFT;
      end
      ntm_pkg::ST_SHIFT: begin
        shift_en   = 1'b1;
        ram_we     = 1'b1;
        state_next = item_prod ? ntm_pkg::ST_ACC : ntm_pkg::ST_IDLE;
      end
      ntm_pkg::ST_ACC: begin
        shift_en = 1'b1;
        if (k == K_W'(TPL_SIZE - 1)) state_next = ntm_pkg::ST_START;
      end
      ntm_pkg::ST_START: begin
        score_start = 1'b1;
        state_next  = ntm_pkg::ST_SCORE;
      end
      ntm_pkg::ST_SCORE: begin
        if (score_done) state_next = ntm_pkg::ST_DONE;
      end
      ntm_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ntm_pkg::ST_IDLE;
        end
      end
      default: state_next = ntm_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // row store
  logic [ROW_W-1:0] rd_data, wr_data;
  col_t             new_col, chain_in;

  ntm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (item_col),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (c0),
    .rd_data (rd_data)
  );

  always_comb begin
    for (int y = 0; y < TPL_SIZE - 1; y++) begin
      new_col[y] = rd_data[ntm_pkg::PIX_W*y +: ntm_pkg::PIX_W];
    end
    new_col[TPL_SIZE-1] = item_pix;
    for (int y = 0; y < TPL_SIZE - 2; y++) begin
      wr_data[ntm_pkg::PIX_W*y +: ntm_pkg::PIX_W] =
        rd_data[ntm_pkg::PIX_W*(y+1) +: ntm_pkg::PIX_W];
    end
    wr_data[ntm_pkg::PIX_W*(TPL_SIZE-2) +: ntm_pkg::PIX_W] = item_pix;
  end

  // window: a chain of column cells, column 0 on the left
  col_t win_col [TPL_SIZE];

  assign chain_in = (state == ntm_pkg::ST_SHIFT) ? new_col : win_col[0];

  for (genvar g = 0; g < TPL_SIZE; g++) begin : g_cell
    if (g == TPL_SIZE - 1) begin : g_tail
      ntm_cell #(.TPL_SIZE(TPL_SIZE)) u_cell (
        .clk    (clk),
        .shift  (shift_en),
        .col_in (chain_in),
        .col    (win_col[g])
      );
    end else begin : g_body
      ntm_cell #(.TPL_SIZE(TPL_SIZE)) u_cell (
        .clk    (clk),
        .shift  (shift_en),
        .col_in (win_col[g+1]),
        .col    (win_col[g])
      );
    end
  end

  // column accumulation during the rotation
  ntm_pkg::sums_t          sums;
  logic [ntm_pkg::PIX_W-1:0] tcol [TPL_SIZE];
  logic [ntm_pkg::SUM_W-1:0] cs_i, cs_t;
  logic [ntm_pkg::SQ_W-1:0]  cs_it, cs_i2, cs_t2;
  logic [ntm_pkg::PROD_W-1:0] m_it, m_i2, m_t2;

  always_comb begin
    cs_i  = '0;
    cs_t  = '0;
    cs_it = '0;
    cs_i2 = '0;
    cs_t2 = '0;
    m_it  = '0;
    m_i2  = '0;
    m_t2  = '0;
    for (int y = 0; y < TPL_SIZE; y++) begin
      tcol[y] = tpl_byte[y*TPL_SIZE + int'(k)];
      m_it    = ntm_pkg::PROD_W'(win_col[0][y]) * ntm_pkg::PROD_W'(tcol[y]);
      m_i2    = ntm_pkg::PROD_W'(win_col[0][y]) * ntm_pkg::PROD_W'(win_col[0][y]);
      m_t2    = ntm_pkg::PROD_W'(tcol[y]) * ntm_pkg::PROD_W'(tcol[y]);
      cs_i    = cs_i + ntm_pkg::SUM_W'(win_col[0][y]);
      cs_t    = cs_t + ntm_pkg::SUM_W'(tcol[y]);
      cs_it   = cs_it + ntm_pkg::SQ_W'(m_it);
      cs_i2   = cs_i2 + ntm_pkg::SQ_W'(m_i2);
      cs_t2   = cs_t2 + ntm_pkg::SQ_W'(m_t2);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ntm_pkg::ST_SHIFT) begin
      sums <= '0;
    end else if (state == ntm_pkg::ST_ACC) begin
      sums.si  <= sums.si + cs_i;
      sums.st  <= sums.st + cs_t;
      sums.sit <= sums.sit + cs_it;
      sums.si2 <= sums.si2 + cs_i2;
      sums.st2 <= sums.st2 + cs_t2;
    end
  end

  logic signed [ntm_pkg::SCORE_W-1:0] unit_score;

  ntm_score #(.TPL_SIZE(TPL_SIZE)) u_score (
    .clk   (clk),
    .rst   (rst),
    .start (score_start),
    .sums  (sums),
    .done  (score_done),
    .score (unit_score)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      score       <= unit_score;
      win_x       <= item_wx;
      win_y       <= item_wy;
      last_window <= item_last;
    end
  end

endmodule

// File: rtl/ntm_checker.sv
// Port-level checker for the template match block, bound to the top level
`include "ncc_template_match_map_macros.svh"

module ntm_checker #(
  parameter int TPL_SIZE = ntm_pkg::TPL_SIZE_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ntm_pkg::SCORE_W-1:0] score,
  input logic [ntm_pkg::COORD_W-1:0]        win_x,
  input logic [ntm_pkg::COORD_W-1:0]        win_y
);

  localparam int N = TPL_SIZE * TPL_SIZE;
  localparam logic signed [ntm_pkg::SCORE_W-1:0] SMAX =
    ntm_pkg::SCORE_W'((16384 * N + N - 2) / (N - 1));

  `NTM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(score) && $stable(win_x) && $stable(win_y), "output changed while stalled")
  `NTM_ASSERT_NOW(a_score_range, out_valid, (score <= SMAX) && (score >= -SMAX), "score out of range")
  `NTM_ASSERT_NOW(a_load_busy, $rose(out_valid), !$past(in_ready), "result loaded while input side idle")

endmodule

bind ncc_template_match_map ntm_checker #(.TPL_SIZE(TPL_SIZE)) u_ntm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .score     (score),
  .win_x     (win_x),
  .win_y     (win_y)
);

// File: test/tb.sv
// Testbench for the streaming 5x5 normalized cross-correlation map block
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [7:0] pix;
    logic       fs;
  } pix_item_t;

  typedef struct {
    logic [15:0] score;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        last;
  } match_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic signed [15:0] score;
  logic [9:0]  win_x;
  logic [9:0]  win_y;
  logic        last_window;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  ncc_template_match_map dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready), .score(score), .win_x(win_x),
    .win_y(win_y), .last_window(last_window),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pix_item_t pix_queue[$];
  match_t    match_queue[$];

  // shadow of the block state
  int         frame_w;
  int         frame_h;
  logic [7:0] tpl [25];
  logic [7:0] line_buf [4][1024];
  logic [7:0] win [5][5];
  int         col_cnt;
  int         row_cnt;

  int  errors;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  hold_req;
  int  rand_items;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] ncc_q14(longint num, longint vi, longint vt);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] d;
    longint an;
    int lo;
    int hi;
    int mid;
    if (vi == 0 || vt == 0) return 16'd0;
    an = (num < 0) ? -num : num;
    rhs = 128'(an) * 128'd819200;
    rhs = rhs * rhs;
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 128'(2 * mid - 1);
      lhs = d * d * 128'd576 * 128'(vi) * 128'(vt);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (num < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  task automatic apply_pixel(logic [7:0] pix, logic fs);
    int ew;
    int eh;
    int c;
    int r;
    int y;
    int x;
    longint si, st, sit, si2, st2, iv, tv;
    match_t m;
    ew = frame_w < 5 ? 5 : (frame_w > 1024 ? 1024 : frame_w);
    eh = frame_h < 5 ? 5 : (frame_h > 1024 ? 1024 : frame_h);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    if (c < ew && r < eh) begin
      for (y = 0; y < 5; y++) begin
        for (x = 0; x < 4; x++) win[y][x] = win[y][x+1];
        win[y][4] = (y < 4) ? line_buf[y][c] : pix;
      end
      for (y = 0; y < 3; y++) line_buf[y][c] = line_buf[y+1][c];
      line_buf[3][c] = pix;
      if (c >= 4 && r >= 4) begin
        si = 0; st = 0; sit = 0; si2 = 0; st2 = 0;
        for (y = 0; y < 5; y++)
          for (x = 0; x < 5; x++) begin
            iv = win[y][x];
            tv = tpl[y*5+x];
            si += iv; st += tv; sit += iv * tv; si2 += iv * iv; st2 += tv * tv;
          end
        m.score = ncc_q14(25 * sit - si * st, 25 * si2 - si * si, 25 * st2 - st * st);
        m.x = 10'(c - 4);
        m.y = 10'(r - 4);
        m.last = (c == ew - 1 && r == eh - 1);
        match_queue = {match_queue, m};
      end
    end
    c++;
    if (c >= ew) begin
      c = 0;
      r++;
      if (r >= eh) r = 0;
    end
    if (r >= eh) r = 0;
    col_cnt = c;
    row_cnt = r;
  endtask

  // sender
  int tx_gap;
  always @(posedge clk) begin
    pix_item_t it;
    logic v;
    if (rst) begin
      in_valid <= 1'b0;
      pixel <= 8'd0;
      frame_start <= 1'b0;
      tx_gap = 0;
    end else begin
      v = in_valid;
      if (in_valid && in_ready) begin
        apply_pixel(pixel, frame_start);
        v = 1'b0;
      end
      if (!v) begin
        if (tx_gap > 0) tx_gap--;
        else if (pix_queue.size() > 0 && $urandom_range(99) < tx_idle_pct)
          tx_gap = $urandom_range(0, 4);
        else if (pix_queue.size() > 0) begin
          it = pix_queue.pop_front();
          pixel <= it.pix;
          frame_start <= it.fs;
          v = 1'b1;
        end
      end
      in_valid <= v;
    end
  end

  // receiver and checker
  int rx_gap;
  int hold_cnt;
  always @(posedge clk) begin
    match_t m;
    logic r;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
      hold_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (match_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer x=%0d y=%0d", win_x, win_y);
        end else begin
          m = match_queue.pop_front();
          if (score !== m.score || win_x !== m.x || win_y !== m.y ||
              last_window !== m.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp score=%0d x=%0d y=%0d last=%b got %0d %0d %0d %b",
                       $signed(m.score), m.x, m.y, m.last, score, win_x, win_y,
                       last_window);
          end
        end
      end
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        r = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        r = 1'b0;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 4);
        r = 1'b0;
      end else r = 1'b1;
      out_ready <= r;
    end
  end

  task automatic write_reg(ntm_pkg::cfg_reg_t idx, logic [63:0] val);
    int i;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ntm_pkg::REG_FRAME_WIDTH:  frame_w = val[10:0];
      ntm_pkg::REG_FRAME_HEIGHT: frame_h = val[10:0];
      ntm_pkg::REG_TPL_WORD_0:   for (i = 0; i < 8; i++) tpl[i] = val[8*i +: 8];
      ntm_pkg::REG_TPL_WORD_1:   for (i = 0; i < 8; i++) tpl[8+i] = val[8*i +: 8];
      ntm_pkg::REG_TPL_WORD_2:   for (i = 0; i < 8; i++) tpl[16+i] = val[8*i +: 8];
      ntm_pkg::REG_TPL_WORD_3:   tpl[24] = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pix_queue.size() != 0 || in_valid || match_queue.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_template(logic [199:0] t);
    write_reg(ntm_pkg::REG_TPL_WORD_0, t[63:0]);
    write_reg(ntm_pkg::REG_TPL_WORD_1, t[127:64]);
    write_reg(ntm_pkg::REG_TPL_WORD_2, t[191:128]);
    write_reg(ntm_pkg::REG_TPL_WORD_3, {56'd0, t[199:192]});
  endtask

  // style: 0 random, 1 constant, 2 tiled template, 3 inverted tiled template
  task automatic push_pixels(int count, int style, int w, bit first_fs, bit counted);
    pix_item_t it;
    int k;
    int ti;
    logic [7:0] flat;
    flat = $urandom_range(0, 255);
    for (k = 0; k < count; k++) begin
      ti = ((k / w) % 5) * 5 + (k % w) % 5;
      case (style)
        1: it.pix = flat;
        2: it.pix = tpl[ti];
        3: it.pix = ~tpl[ti];
        default: it.pix = $urandom_range(0, 255);
      endcase
      if (style != 0 && $urandom_range(9) == 0) it.pix = $urandom_range(0, 255);
      it.fs = (k == 0) ? first_fs : ($urandom_range(199) == 0);
      pix_queue = {pix_queue, it};
      if (counted) rand_items++;
    end
  endtask

  function automatic logic [199:0] rand_template(int kind);
    logic [199:0] t;
    int i;
    for (i = 0; i < 25; i++)
      case (kind)
        0: t[8*i +: 8] = 8'd0;
        1: t[8*i +: 8] = 8'hA5;
        default: t[8*i +: 8] = $urandom_range(0, 255);
      endcase
    return t;
  endfunction

  initial begin
    logic [199:0] ramp;
    int i;
    int w;
    int h;
    int phase;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel = 8'd0;
    frame_start = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ntm_pkg::REG_FRAME_WIDTH;
    cfg_data = 64'd0;
    errors = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    hold_req = 0;
    rand_items = 0;
    frame_w = 640;
    frame_h = 480;
    for (i = 0; i < 25; i++) tpl[i] = 8'd0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: clamped 5x5 frame, matching / inverted / flat / all-zero template
    write_reg(ntm_pkg::REG_FRAME_WIDTH, 64'd0);
    write_reg(ntm_pkg::REG_FRAME_HEIGHT, 64'd3);
    for (i = 0; i < 25; i++) ramp[8*i +: 8] = (i == 24) ? 8'd255 : 8'(i * 10);
    load_template(ramp);
    begin
      pix_item_t it;
      for (i = 0; i < 25; i++) begin
        it.pix = tpl[i]; it.fs = (i == 0); pix_queue = {pix_queue, it};
      end
      for (i = 0; i < 25; i++) begin
        it.pix = ~tpl[i]; it.fs = (i == 0); pix_queue = {pix_queue, it};
      end
      for (i = 0; i < 25; i++) begin
        it.pix = 8'd255; it.fs = 1'b0; pix_queue = {pix_queue, it};
      end
    end
    drain();
    load_template(rand_template(0));
    push_pixels(25, 0, 5, 1'b0, 1'b0);
    drain();

    // long receiver hold while pixels keep coming
    write_reg(ntm_pkg::REG_FRAME_WIDTH, 64'd8);
    write_reg(ntm_pkg::REG_FRAME_HEIGHT, 64'd6);
    load_template(rand_template(2));
    hold_req = 300;
    push_pixels(48, 0, 8, 1'b1, 1'b0);
    drain();

    // width shrunk in the middle of a frame, below the current column
    write_reg(ntm_pkg::REG_FRAME_WIDTH, 64'd12);
    write_reg(ntm_pkg::REG_FRAME_HEIGHT, 64'd8);
    push_pixels(57, 0, 12, 1'b1, 1'b0);
    drain();
    write_reg(ntm_pkg::REG_FRAME_WIDTH, 64'd6);
    push_pixels(60, 0, 6, 1'b0, 1'b0);
    drain();

    phase = 0;
    while (rand_items < 120) begin
      w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : $urandom_range(5, 10);
      h = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : $urandom_range(5, 8);
      write_reg(ntm_pkg::REG_FRAME_WIDTH, 64'(w));
      write_reg(ntm_pkg::REG_FRAME_HEIGHT, 64'(h));
      load_template(rand_template($urandom_range(0, 7)));
      if (w < 5) w = 5;
      if (h < 5) h = 5;
      if (rand_items > 80) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(3) == 0) ? 0 : 25;
        rx_idle_pct = ($urandom_range(3) == 0) ? 0 : 25;
      end
      push_pixels(w * h + $urandom_range(0, w * h), $urandom_range(0, 3), w, 1'b1, 1'b1);
      drain();
      phase++;
    end

    drain();
    if (match_queue.size() != 0) errors++;
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
